[rtl/ebr_pkg.sv]
`default_nettype none

package ebr_pkg;

    localparam int LEVEL_W = 10;
    localparam int TOTAL_W = 12;
    localparam int NUM_W   = 17;
    localparam int DIV_W   = 18;
    localparam int SHARE_W = 7;
    localparam int LIMIT_W = 7;
    localparam int LANES   = 4;
    localparam int SCALE   = 100;

    localparam int LANE_DELTA = 0;
    localparam int LANE_THETA = 1;
    localparam int LANE_ALPHA = 2;
    localparam int LANE_BETA  = 3;

    localparam logic [LIMIT_W-1:0] DELTA_LIMIT_RST = 7'd50;
    localparam logic [LIMIT_W-1:0] THETA_LIMIT_RST = 7'd40;
    localparam logic [LIMIT_W-1:0] ALPHA_LIMIT_RST = 7'd40;
    localparam logic [LIMIT_W-1:0] BETA_LIMIT_RST  = 7'd45;

    typedef enum logic [1:0] {
        CFG_DELTA_LIMIT = 2'd0,
        CFG_THETA_LIMIT = 2'd1,
        CFG_ALPHA_LIMIT = 2'd2,
        CFG_BETA_LIMIT  = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        MS_NO_SIGNAL  = 3'd0,
        MS_DEEP_SLEEP = 3'd1,
        MS_DROWSY     = 3'd2,
        MS_RELAXED    = 3'd3,
        MS_FOCUSED    = 3'd4
    } mind_state_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] delta;
        logic [LIMIT_W-1:0] theta;
        logic [LIMIT_W-1:0] alpha;
        logic [LIMIT_W-1:0] beta;
    } limits_t;

    // One set of bands in flight through the divider: the running
    // remainders and the quotient bits found so far, one lane per band.
    typedef struct packed {
        logic [TOTAL_W-1:0]                total;
        logic [LANES-1:0][NUM_W-1:0]       rem;
        logic [LANES-1:0][SHARE_W-1:0]     quo;
    } ebr_div_t;

endpackage

`default_nettype wire

[rtl/ebr_if.sv]
`default_nettype none

interface band_in_if;
    logic                        valid;
    logic                        ready;
    logic [ebr_pkg::LEVEL_W-1:0] delta_level;
    logic [ebr_pkg::LEVEL_W-1:0] theta_level;
    logic [ebr_pkg::LEVEL_W-1:0] alpha_level;
    logic [ebr_pkg::LEVEL_W-1:0] beta_level;

    modport source (output valid, output delta_level, output theta_level,
                    output alpha_level, output beta_level, input ready);
    modport sink   (input valid, input delta_level, input theta_level,
                    input alpha_level, input beta_level, output ready);
endinterface

interface share_out_if;
    logic                        valid;
    logic                        ready;
    logic [ebr_pkg::SHARE_W-1:0] delta_share;
    logic [ebr_pkg::SHARE_W-1:0] theta_share;
    logic [ebr_pkg::SHARE_W-1:0] alpha_share;
    logic [ebr_pkg::SHARE_W-1:0] beta_share;
    logic [2:0]                  mind_state;

    modport source (output valid, output delta_share, output theta_share,
                    output alpha_share, output beta_share, output mind_state,
                    input ready);
    modport sink   (input valid, input delta_share, input theta_share,
                    input alpha_share, input beta_share, input mind_state,
                    output ready);
endinterface

`default_nettype wire

[rtl/eeg_band_ratio_classifier.sv]
// EEG band ratio classifier.
// A request on band_in carries four averaged band amplitudes (delta, theta,
// alpha, beta). For each request the block returns one request on share_out
// with each band's truncated percent of the sum and a mind state code chosen
// in priority order: deep sleep, drowsy, relaxed, focused, with relaxed as
// the fallback and no-signal when all bands are zero.
// Both channels use a valid/ready handshake; a request moves on a rising
// edge where valid and ready are both high.
// The four percent limits are written through cfg_we, cfg_index and
// cfg_data while no request is in flight; index 0 is delta, 3 is beta.
// From input to output, one stage forms the sum and the
// scaled amplitudes, seven stages each resolve one quotient bit of the four
// parallel restoring dividers, and one stage classifies and holds the result.
// Throughput is one request per cycle, set by the one-bit-per-stage divider,
// as long as the receiver takes results. When the receiver stalls, every
// stage holds its contents and ready backs up through the pipeline; a free
// stage still takes new data, so nothing is lost or repeated. Reset empties
// the pipeline and loads the default limits (50, 40, 40, 45 percent).
`default_nettype none

module eeg_band_ratio_classifier (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    band_in_if.sink                        band_in,
    share_out_if.source                    share_out,
    input  wire logic                      cfg_we,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [ebr_pkg::LIMIT_W-1:0] cfg_data
);
    import ebr_pkg::*;

    limits_t  limits_reg;
    limits_t  limits_next;

    ebr_div_t div_data  [SHARE_W+1];
    logic     div_valid [SHARE_W+1];
    logic     div_ready [SHARE_W+1];

    // Limit registers; write only while the pipeline is empty (not enforced).
    always_comb
    begin
        limits_next = limits_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_DELTA_LIMIT: limits_next.delta = cfg_data;
                CFG_THETA_LIMIT: limits_next.theta = cfg_data;
                CFG_ALPHA_LIMIT: limits_next.alpha = cfg_data;
                CFG_BETA_LIMIT:  limits_next.beta  = cfg_data;
                default:         limits_next = limits_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.delta <= DELTA_LIMIT_RST;
            limits_reg.theta <= THETA_LIMIT_RST;
            limits_reg.alpha <= ALPHA_LIMIT_RST;
            limits_reg.beta  <= BETA_LIMIT_RST;
        end
        else
        begin
            limits_reg <= limits_next;
        end
    end

    ebr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .band_in   (band_in),
        .out_valid (div_valid[0]),
        .out_data  (div_data[0]),
        .out_ready (div_ready[0])
    );

    // Quotient bits are resolved from the most significant one down.
    for (genvar k = 0; k < SHARE_W; k++)
    begin : g_div
        ebr_div_stage #(
            .STEP (SHARE_W - 1 - k)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[k]),
            .in_data   (div_data[k]),
            .in_ready  (div_ready[k]),
            .out_valid (div_valid[k+1]),
            .out_data  (div_data[k+1]),
            .out_ready (div_ready[k+1])
        );
    end

    ebr_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid[SHARE_W]),
        .in_data   (div_data[SHARE_W]),
        .in_ready  (div_ready[SHARE_W]),
        .limits    (limits_reg),
        .share_out (share_out)
    );

endmodule

`default_nettype wire

[rtl/ebr_front.sv]
`default_nettype none

module ebr_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    band_in_if.sink            band_in,
    output logic               out_valid,
    output ebr_pkg::ebr_div_t  out_data,
    input  wire logic          out_ready
);
    import ebr_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    ebr_div_t data_reg;
    ebr_div_t data_next;
    logic     take;

    assign band_in.ready = !valid_reg || out_ready;
    assign take          = band_in.valid && band_in.ready;
    assign valid_next    = take ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    // Sum the bands and scale each one by the percent factor.
    always_comb
    begin
        data_next.total = TOTAL_W'(band_in.delta_level) + TOTAL_W'(band_in.theta_level)
                        + TOTAL_W'(band_in.alpha_level) + TOTAL_W'(band_in.beta_level);
        data_next.rem[LANE_DELTA] = NUM_W'(band_in.delta_level) * NUM_W'(SCALE);
        data_next.rem[LANE_THETA] = NUM_W'(band_in.theta_level) * NUM_W'(SCALE);
        data_next.rem[LANE_ALPHA] = NUM_W'(band_in.alpha_level) * NUM_W'(SCALE);
        data_next.rem[LANE_BETA]  = NUM_W'(band_in.beta_level)  * NUM_W'(SCALE);
        data_next.quo = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

[rtl/ebr_div_stage.sv]
`default_nettype none

module ebr_div_stage #(
    parameter int STEP = 0
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire ebr_pkg::ebr_div_t  in_data,
    output logic                    in_ready,
    output logic                    out_valid,
    output ebr_pkg::ebr_div_t       out_data,
    input  wire logic               out_ready
);
    import ebr_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    ebr_div_t data_reg;
    ebr_div_t data_next;
    logic     take;

    assign in_ready   = !valid_reg || out_ready;
    assign take       = in_valid && in_ready;
    assign valid_next = take ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    // One restoring step per lane: try to subtract total shifted by this
    // stage's quotient bit position.
    always_comb
    begin
        logic [DIV_W-1:0] trial;
        logic [DIV_W-1:0] rem_ext;
        logic             fits;
        data_next = in_data;
        trial     = DIV_W'(in_data.total) << STEP;
        for (int l = 0; l < LANES; l++)
        begin
            rem_ext = DIV_W'(in_data.rem[l]);
            fits    = rem_ext >= trial;
            if (fits)
            begin
                data_next.rem[l] = NUM_W'(rem_ext - trial);
            end
            data_next.quo[l][STEP] = fits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

[rtl/ebr_classify.sv]
`default_nettype none

module ebr_classify (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire ebr_pkg::ebr_div_t  in_data,
    output logic                    in_ready,
    input  wire ebr_pkg::limits_t   limits,
    share_out_if.source             share_out
);
    import ebr_pkg::*;

    logic                              valid_reg;
    logic                              valid_next;
    logic [LANES-1:0][SHARE_W-1:0]     share_reg;
    logic [LANES-1:0][SHARE_W-1:0]     share_next;
    mind_state_t                       state_reg;
    mind_state_t                       state_next;
    logic                              take;
    logic                              zero_total;

    assign in_ready   = !valid_reg || share_out.ready;
    assign take       = in_valid && in_ready;
    assign valid_next = take ? 1'b1 : (share_out.ready ? 1'b0 : valid_reg);
    assign zero_total = in_data.total == '0;

    // A zero total makes every divider step succeed, so the shares are
    // forced to zero here; otherwise the bands are checked in priority order.
    always_comb
    begin
        share_next = zero_total ? '0 : in_data.quo;
        if (zero_total)
        begin
            state_next = MS_NO_SIGNAL;
        end
        else if (in_data.quo[LANE_DELTA] >= limits.delta)
        begin
            state_next = MS_DEEP_SLEEP;
        end
        else if (in_data.quo[LANE_THETA] >= limits.theta)
        begin
            state_next = MS_DROWSY;
        end
        else if (in_data.quo[LANE_ALPHA] >= limits.alpha)
        begin
            state_next = MS_RELAXED;
        end
        else if (in_data.quo[LANE_BETA] >= limits.beta)
        begin
            state_next = MS_FOCUSED;
        end
        else
        begin
            state_next = MS_RELAXED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            share_reg <= share_next;
            state_reg <= state_next;
        end
    end

    assign share_out.valid       = valid_reg;
    assign share_out.delta_share = share_reg[LANE_DELTA];
    assign share_out.theta_share = share_reg[LANE_THETA];
    assign share_out.alpha_share = share_reg[LANE_ALPHA];
    assign share_out.beta_share  = share_reg[LANE_BETA];
    assign share_out.mind_state  = state_reg;

endmodule

`default_nettype wire
